// ----- hw/rtl/rmps_pkg.sv -----
// Package with the shared types and constants of the mine placement shuffle block.
`timescale 1ns / 1ps
`default_nettype none

package rmps_pkg;

  // Fixed field widths of the request and result transactions.
  localparam int SEED_W  = 64;
  localparam int COUNT_W = 6;
  localparam int MAP_W   = 32;

  // xorshift64 shift amounts and the stand-in for a zero seed.
  localparam int XS_SHIFT_A = 13;
  localparam int XS_SHIFT_B = 7;
  localparam int XS_SHIFT_C = 17;
  localparam logic [SEED_W-1:0] ZERO_SEED_SUBST = 64'h0000_0000_DEAD_BEEF;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW,
    S_DIVIDE,
    S_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rmps_if.sv -----
// Valid/ready channel interfaces for the request and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface rmps_req_if;
  import rmps_pkg::*;

  logic               valid;
  logic               ready;
  logic [SEED_W-1:0]  seed;
  logic [COUNT_W-1:0] mine_total;

  modport source (output valid, seed, mine_total, input ready);
  modport sink   (input valid, seed, mine_total, output ready);
endinterface

interface rmps_res_if;
  import rmps_pkg::*;

  logic             valid;
  logic             ready;
  logic [MAP_W-1:0] mine_map;
  logic             count_error;

  modport source (output valid, mine_map, count_error, input ready);
  modport sink   (input valid, mine_map, count_error, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rmps_mod_unit.sv -----
// Bit-serial remainder unit: 64-bit dividend modulo a small divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rmps_mod_unit #(
  parameter int DW = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rmps_pkg::SEED_W-1:0] dividend,
  input  wire logic [DW-1:0]              divisor,
  output logic                            done,
  output logic [DW-1:0]                   remainder
);
  import rmps_pkg::*;

  localparam int CNT_W = $clog2(SEED_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SEED_W-1:0] dvd;
  logic [DW-1:0]     div_q;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     trial;
  logic [DW-1:0]     rem_next;

  // The partial remainder stays below the divisor, so its top bit is free for the shift.
  assign trial    = {rem[DW-2:0], dvd[SEED_W-1]};
  assign rem_next = (trial >= div_q) ? (trial - div_q) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SEED_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      div_q <= divisor;
      rem   <= '0;
    end else if (busy) begin
      dvd <= {dvd[SEED_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < div_q))
    else $error("remainder not reduced below divisor");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit started while busy");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("remainder unit did not begin after start");

endmodule

`default_nettype wire

// ----- hw/rtl/random_mine_placement_shuffle_unit.sv -----
// Top level of the mine placement block: Fisher-Yates shuffle driven by xorshift64.
//
//  Channel  | Direction | Payload                         | Handshake
//  ---------+-----------+---------------------------------+-------------
//  request  | sink      | seed[63:0], mine_total[5:0]     | valid/ready
//  result   | source    | mine_map[31:0], count_error     | valid/ready
//
// A valid request shuffles the grid, 32 tiles at the default setting. Each shuffle step
// advances the generator in the draw state and then waits in the divide state for
// the bit-serial remainder unit, which walks the 64 bits of the draw one per cycle.
// A request with an out-of-range count skips the shuffle and returns an error result.
// Reset is synchronous and returns the sequencer to idle with no result pending.
// A result waits in the output register while the next request is accepted; a full
// output register only holds the sequencer in its last state.
`timescale 1ns / 1ps
`default_nettype none

module random_mine_placement_shuffle_unit #(
  parameter int GRID_TILES = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  rmps_req_if.sink  request,
  rmps_res_if.source result
);
  import rmps_pkg::*;

  // Index width covers tiles 0 to GRID_TILES-1; the divisor i+1 needs one more bit.
  localparam int IW = (GRID_TILES > 2) ? $clog2(GRID_TILES) : 1;
  localparam int DW = IW + 1;
  localparam logic [COUNT_W:0] GRID_C = (COUNT_W + 1)'(GRID_TILES);

  seq_state_t state;
  seq_state_t state_next;

  logic [GRID_TILES-1:0] work_map;
  logic [SEED_W-1:0]     gen;
  logic [IW-1:0]         idx;
  logic                  err;

  logic             res_valid;
  logic [MAP_W-1:0] res_map;
  logic             res_err;

  logic                  accept;
  logic                  count_ok;
  logic [GRID_TILES-1:0] init_map;
  logic [SEED_W-1:0]     xs1;
  logic [SEED_W-1:0]     xs2;
  logic [SEED_W-1:0]     xs3;
  logic [DW-1:0]         divisor;
  logic                  mod_start;
  logic                  mod_done;
  logic [DW-1:0]         mod_rem;
  logic [IW-1:0]         jdx;
  logic [GRID_TILES-1:0] swap_map;
  logic                  out_load;
  logic [MAP_W+GRID_TILES-1:0] map_ext;

  assign accept = request.valid && request.ready;

  // Counts from 1 to GRID_TILES-1 are placed; anything else is an error result.
  assign count_ok = (request.mine_total != '0) && ({1'b0, request.mine_total} < GRID_C);

  // The lowest mine_total tiles start out as mines.
  always_comb begin
    for (int k = 0; k < GRID_TILES; k++) begin
      init_map[k] = ((COUNT_W + 1)'(k) < {1'b0, request.mine_total});
    end
  end

  // One xorshift64 step: three shift-and-xor stages.
  assign xs1 = gen ^ (gen << XS_SHIFT_A);
  assign xs2 = xs1 ^ (xs1 >> XS_SHIFT_B);
  assign xs3 = xs2 ^ (xs2 << XS_SHIFT_C);

  // The draw is reduced modulo i+1 by the shared serial remainder unit.
  assign divisor = DW'(idx) + DW'(1);

  rmps_mod_unit #(
    .DW (DW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (xs3),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // The remainder is below i+1, so it always names a tile of the grid.
  assign jdx = mod_rem[IW-1:0];

  // Exchange tiles i and j; when they coincide the map is unchanged.
  always_comb begin
    swap_map      = work_map;
    swap_map[idx] = work_map[jdx];
    swap_map[jdx] = work_map[idx];
  end

  // Only tiles 0 to 31 are visible; a narrower grid is padded with empty tiles.
  assign map_ext = {MAP_W'(0), work_map};

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = count_ok ? S_DRAW : S_FINISH;
        end
      end
      S_DRAW: begin
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (mod_done) begin
          state_next = (idx == IW'(1)) ? S_FINISH : S_DRAW;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    request.ready = (state == S_IDLE);
    mod_start     = (state == S_DRAW);
    out_load      = (state == S_FINISH) && (!res_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Shuffle datapath and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      work_map <= count_ok ? init_map : '0;
      gen      <= (request.seed == '0) ? ZERO_SEED_SUBST : request.seed;
      idx      <= IW'(GRID_TILES - 1);
      err      <= !count_ok;
    end else if (state == S_DRAW) begin
      gen <= xs3;
    end else if ((state == S_DIVIDE) && mod_done) begin
      work_map <= swap_map;
      idx      <= idx - IW'(1);
    end
    if (out_load) begin
      res_map <= map_ext[MAP_W-1:0];
      res_err <= err;
    end
  end

  assign result.valid       = res_valid;
  assign result.mine_map    = res_map;
  assign result.count_error = res_err;

  a_error_map_empty: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.count_error) |-> (result.mine_map == '0))
    else $error("error result carries a nonzero map");

  a_done_only_dividing: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_DIVIDE))
    else $error("remainder finished outside the divide state");

  a_map_held_while_dividing: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIVIDE) && $past(state == S_DIVIDE) && !$past(mod_done))
      |-> $stable(work_map))
    else $error("working map changed while a draw was being reduced");

  a_draw_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW) |-> (idx != '0))
    else $error("shuffle step started at index zero");

endmodule

`default_nettype wire
